FILE: design/gffp_pkg.sv
// Shared types and constants for the grid first-fit placer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package gffp_pkg;

    localparam logic [1:0] ST_PLACED  = 2'd0;
    localparam logic [1:0] ST_NOROOM  = 2'd1;
    localparam logic [1:0] ST_CLEARED = 2'd2;

    localparam logic       CMD_PLACE  = 1'b0;
    localparam logic       CMD_CLEAR  = 1'b1;

    localparam logic [6:0] COUNT_MAX  = 7'd127;

    typedef struct packed {
        logic       command;
        logic [3:0] rect_width;
        logic [3:0] rect_height;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic [6:0] slot;
        logic [6:0] placed_count;
    } t_out_item;

    typedef struct packed {
        logic       clear;
        logic       too_big;
        logic [3:0] w;
        logic [3:0] h;
    } t_op;

endpackage

`default_nettype wire

FILE: design/grid_first_fit_placer.sv
// Top level of the grid first-fit placer: request front end feeding the scan back end.
// Depends on gffp_pkg, gffp_front and gffp_back.
//
//   channel   handshake          payload       direction
//   request   push / full        i_in_item     in
//   result    empty / pop        o_out_item    out
//
// A place beat passes from the request queue to the scan engine, which then scans one
// candidate cell per cycle, row-major, until it finds room or reaches the last cell.
// Clear and oversize beats complete without a scan.
// The engine returns to idle between beats; the two-entry queue keeps taking beats.
// A result that is not popped holds the engine; the map commits only with the result.
// Synchronous active-low reset empties the map, the count, the request queue and the result register.
`timescale 1ns / 1ps
`default_nettype none

module grid_first_fit_placer import gffp_pkg::*; #(
    parameter int GRID_COLS = 8,
    parameter int GRID_ROWS = 15
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire t_in_item i_in_item,
    output logic          empty,
    input  wire logic     pop,
    output t_out_item     o_out_item
);

    logic w_op_vld;
    t_op  w_op;
    logic w_op_take;

    gffp_front #(
        .GRID_COLS (GRID_COLS),
        .GRID_ROWS (GRID_ROWS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .o_full    (full),
        .i_in_item (i_in_item),
        .o_op_vld  (w_op_vld),
        .o_op      (w_op),
        .i_op_take (w_op_take)
    );

    gffp_back #(
        .GRID_COLS (GRID_COLS),
        .GRID_ROWS (GRID_ROWS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_vld   (w_op_vld),
        .i_op       (w_op),
        .o_op_take  (w_op_take),
        .o_empty    (empty),
        .i_pop      (pop),
        .o_out_item (o_out_item)
    );

endmodule

`default_nettype wire

FILE: design/gffp_front.sv
// Front end: accepts request beats, classifies them and queues them (two entries).
// Depends on gffp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gffp_front import gffp_pkg::*; #(
    parameter int GRID_COLS = 8,
    parameter int GRID_ROWS = 15
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    output logic          o_full,
    input  wire t_in_item i_in_item,
    output logic          o_op_vld,
    output t_op           o_op,
    input  wire logic     i_op_take
);

    t_op        r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       w_wr;
    logic       w_rd;
    t_op        w_op;

    always_comb begin
        w_op.clear   = (i_in_item.command == CMD_CLEAR);
        w_op.too_big = ({2'b00, i_in_item.rect_width}  > 6'(GRID_COLS)) ||
                       ({2'b00, i_in_item.rect_height} > 6'(GRID_ROWS));
        w_op.w       = i_in_item.rect_width;
        w_op.h       = i_in_item.rect_height;
    end

    assign o_full   = (r_cnt == 2'd2);
    assign o_op_vld = (r_cnt != 2'd0);
    assign o_op     = r_q[r_rp];
    assign w_wr     = i_push && !o_full;
    assign w_rd     = i_op_take && o_op_vld;

    always_comb begin
        n_cnt = r_cnt;
        if (w_wr && !w_rd) begin
            n_cnt = r_cnt + 2'd1;
        end else if (w_rd && !w_wr) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wp] <= w_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wp <= ~r_wp;
            end
            if (w_rd) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

FILE: design/gffp_back.sv
// Back end: occupancy map, candidate scan (one cell a cycle) and result register.
// Depends on gffp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gffp_back import gffp_pkg::*; #(
    parameter int GRID_COLS = 8,
    parameter int GRID_ROWS = 15
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_op_vld,
    input  wire t_op  i_op,
    output logic      o_op_take,
    output logic      o_empty,
    input  wire logic i_pop,
    output t_out_item o_out_item
);

    localparam int CW = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
    localparam int RW = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    logic                 r_state;
    t_op                  r_op;
    logic [CW-1:0]        r_sx;
    logic [RW-1:0]        r_sy;
    logic [GRID_COLS-1:0] r_rows [GRID_ROWS];
    logic [6:0]           r_total;
    logic                 r_res_vld;
    t_out_item            r_res;

    logic [GRID_COLS-1:0] w_mask;
    logic [GRID_ROWS-1:0] w_rsel;
    logic [6:0]           w_sx_end;
    logic [6:0]           w_sy_end;
    logic                 w_hit;
    logic                 w_cell;
    logic                 w_found;
    logic                 w_last;
    logic                 w_can_load;
    logic                 w_done;
    logic [11:0]          w_slot;
    logic [6:0]           w_total_inc;

    assign w_sx_end = 7'(r_sx) + 7'(r_op.w);
    assign w_sy_end = 7'(r_sy) + 7'(r_op.h);

    always_comb begin
        for (int c = 0; c < GRID_COLS; c++) begin
            w_mask[c] = (7'(c) >= 7'(r_sx)) && (7'(c) < w_sx_end);
        end
        for (int r = 0; r < GRID_ROWS; r++) begin
            w_rsel[r] = (7'(r) >= 7'(r_sy)) && (7'(r) < w_sy_end);
        end
    end

    always_comb begin
        w_hit  = 1'b0;
        w_cell = 1'b0;
        for (int r = 0; r < GRID_ROWS; r++) begin
            if (w_rsel[r] && ((r_rows[r] & w_mask) != '0)) begin
                w_hit = 1'b1;
            end
            if (RW'(r) == r_sy) begin
                w_cell = r_rows[r][r_sx];
            end
        end
    end

    assign w_found = !w_cell && !w_hit &&
                     (w_sx_end <= 7'(GRID_COLS)) && (w_sy_end <= 7'(GRID_ROWS));
    assign w_last  = (r_sx == CW'(GRID_COLS - 1)) && (r_sy == RW'(GRID_ROWS - 1));
    assign w_slot  = 12'(r_sx) + 12'(r_sy) * 12'(GRID_COLS);
    assign w_total_inc = (r_total < COUNT_MAX) ? (r_total + 7'd1) : r_total;

    assign w_can_load = !r_res_vld || i_pop;
    assign w_done     = (r_state == S_RUN) && w_can_load &&
                        (r_op.clear || r_op.too_big || w_found || w_last);
    assign o_op_take  = (r_state == S_IDLE) && i_op_vld;
    assign o_empty    = !r_res_vld;
    assign o_out_item = r_res;

    always_ff @(posedge i_clk) begin
        if (o_op_take) begin
            r_op <= i_op;
        end
        if ((r_state == S_RUN) && w_can_load) begin
            if (r_op.clear) begin
                r_res.status       <= ST_CLEARED;
                r_res.slot         <= 7'd0;
                r_res.placed_count <= 7'd0;
            end else if (!r_op.too_big && w_found) begin
                r_res.status       <= ST_PLACED;
                r_res.slot         <= w_slot[6:0];
                r_res.placed_count <= w_total_inc;
            end else begin
                r_res.status       <= ST_NOROOM;
                r_res.slot         <= 7'd0;
                r_res.placed_count <= r_total;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_sx      <= '0;
            r_sy      <= '0;
            r_total   <= 7'd0;
            r_res_vld <= 1'b0;
            for (int r = 0; r < GRID_ROWS; r++) begin
                r_rows[r] <= '0;
            end
        end else begin
            if (w_done) begin
                r_res_vld <= 1'b1;
            end else if (i_pop && r_res_vld) begin
                r_res_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_sx <= '0;
                    r_sy <= '0;
                    if (o_op_take) begin
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (r_op.clear || r_op.too_big) begin
                        if (w_can_load) begin
                            r_state <= S_IDLE;
                            if (r_op.clear) begin
                                r_total <= 7'd0;
                                for (int r = 0; r < GRID_ROWS; r++) begin
                                    r_rows[r] <= '0;
                                end
                            end
                        end
                    end else if (w_found || w_last) begin
                        if (w_can_load) begin
                            r_state <= S_IDLE;
                            if (w_found) begin
                                r_total <= w_total_inc;
                                for (int r = 0; r < GRID_ROWS; r++) begin
                                    if (w_rsel[r]) begin
                                        r_rows[r] <= r_rows[r] | w_mask;
                                    end
                                end
                            end
                        end
                    end else begin
                        if (r_sx == CW'(GRID_COLS - 1)) begin
                            r_sx <= '0;
                            r_sy <= r_sy + RW'(1);
                        end else begin
                            r_sx <= r_sx + CW'(1);
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
